/* rtl/core/distance_protection_element_assert.svh */
// assertion macros for the distance protection element
`ifndef DISTANCE_PROTECTION_ELEMENT_ASSERT_SVH
`define DISTANCE_PROTECTION_ELEMENT_ASSERT_SVH

`ifndef SYNTH

`define DPE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define DPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define DPE_ASSERT_SAME(label, ante, cons)

`define DPE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/core/dpe_pkg.sv */
// shared types and constants of the distance protection element
`default_nettype none

package dpe_pkg;

    localparam int PhasesDefault = 4;
    localparam int PhaseWidth    = 2;
    localparam int MaskWidth     = 4;
    localparam int MagWidth      = 16;
    localparam int AngleWidth    = 16;
    localparam int ElapsedWidth  = 20;
    localparam int TimerWidth    = 32;
    localparam int ReachWidth    = 16;
    localparam int ProdWidth     = 32;
    localparam int CfgIdxWidth   = 3;
    localparam int CfgDataWidth  = 64;

    typedef enum logic [1:0] {
        DIR_NONE    = 2'd0,
        DIR_FORWARD = 2'd1,
        DIR_REVERSE = 2'd2,
        DIR_ALT     = 2'd3
    } t_dir_mode;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_PHASE_MASK = 3'd0,
        CFG_DIR_MODE   = 3'd1,
        CFG_IMP_ANGLE  = 3'd2,
        CFG_ANGLE_TOL  = 3'd3,
        CFG_DELAY      = 3'd4,
        CFG_MIN_VOLT   = 3'd5,
        CFG_MIN_CURR   = 3'd6,
        CFG_REACH      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                 enabled;
        logic                 pre_ok;
        logic [ProdWidth-1:0] reach_prod;
    } t_front;

endpackage

`default_nettype wire

/* rtl/core/dpe_front.sv */
// first stage checks: enable, thresholds, direction and reach product
`default_nettype none

module dpe_front #(
    parameter int PHASES = dpe_pkg::PhasesDefault
) (
    input  wire logic [dpe_pkg::PhaseWidth-1:0]   i_phase,
    input  wire logic [dpe_pkg::MagWidth-1:0]     i_voltage_magnitude,
    input  wire logic [dpe_pkg::MagWidth-1:0]     i_current_magnitude,
    input  wire logic [dpe_pkg::AngleWidth-1:0]   i_voltage_angle,
    input  wire logic [dpe_pkg::AngleWidth-1:0]   i_current_angle,
    input  wire logic [dpe_pkg::MaskWidth-1:0]    i_phase_mask,
    input  wire logic [1:0]                       i_dir_mode,
    input  wire logic [dpe_pkg::AngleWidth-1:0]   i_imp_angle,
    input  wire logic [dpe_pkg::AngleWidth-1:0]   i_angle_tol,
    input  wire logic [dpe_pkg::MagWidth-1:0]     i_min_volt,
    input  wire logic [dpe_pkg::MagWidth-1:0]     i_min_curr,
    input  wire logic [dpe_pkg::CfgDataWidth-1:0] i_reach_table,
    output dpe_pkg::t_front                       o_front
);

    logic [dpe_pkg::ReachWidth-1:0] w_reach;
    logic [dpe_pkg::AngleWidth-1:0] w_z;
    logic [dpe_pkg::AngleWidth-1:0] w_d;
    logic [dpe_pkg::AngleWidth:0]   w_abs;
    logic                           w_dir_ok;
    logic                           w_in_range;

    assign w_in_range = ({30'd0, i_phase} < PHASES);
    assign w_reach    = i_reach_table[{i_phase, 4'b0000} +: dpe_pkg::ReachWidth];
    assign w_z        = i_voltage_angle - i_current_angle;

    always_comb begin
        w_d = w_z - i_imp_angle;
        if (dpe_pkg::t_dir_mode'(i_dir_mode) == dpe_pkg::DIR_REVERSE) begin
            w_d[dpe_pkg::AngleWidth-1] = ~w_d[dpe_pkg::AngleWidth-1];
        end
        if (w_d[dpe_pkg::AngleWidth-1]) begin
            w_abs = 17'h10000 - {1'b0, w_d};
        end else begin
            w_abs = {1'b0, w_d};
        end
    end

    always_comb begin
        unique case (dpe_pkg::t_dir_mode'(i_dir_mode))
            dpe_pkg::DIR_FORWARD,
            dpe_pkg::DIR_REVERSE: w_dir_ok = (w_abs <= {1'b0, i_angle_tol});
            dpe_pkg::DIR_NONE,
            dpe_pkg::DIR_ALT:     w_dir_ok = 1'b1;
            default:              w_dir_ok = 1'b1;
        endcase
    end

    always_comb begin
        o_front.enabled    = w_in_range && i_phase_mask[i_phase];
        o_front.pre_ok     = (i_voltage_magnitude >= i_min_volt)
                          && (i_current_magnitude >= i_min_curr)
                          && (i_current_magnitude != '0)
                          && (w_reach != '0)
                          && w_dir_ok;
        o_front.reach_prod = w_reach * i_current_magnitude;
    end

endmodule

`default_nettype wire

/* rtl/core/distance_protection_element.sv */
// top level of the distance protection element: timer ram, zone check, result register
//
// channel   dir  handshake           payload
// input     in   i_valid / o_ready   i_phase, magnitudes, angles, i_elapsed_us
// result    out  o_valid / i_ready   o_result_phase, o_started, o_tripped
// config    in   i_cfg_we            i_cfg_idx, i_cfg_data
//
// one beat per cycle sustained while i_ready holds; compare stage, then result register
// timer state sits in a PHASES-entry ram with a registered read; a write of the
// same phase in the accepting cycle is forwarded into the read register
// reset clears per-entry valid bits at once, no clearing sweep
// a stalled result holds the compare stage, which then holds the input
`default_nettype none

module distance_protection_element #(
    parameter int PHASES = dpe_pkg::PhasesDefault
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic [dpe_pkg::PhaseWidth-1:0]     i_phase,
    input  wire logic [dpe_pkg::MagWidth-1:0]       i_voltage_magnitude,
    input  wire logic [dpe_pkg::MagWidth-1:0]       i_current_magnitude,
    input  wire logic signed [dpe_pkg::AngleWidth-1:0] i_voltage_angle,
    input  wire logic signed [dpe_pkg::AngleWidth-1:0] i_current_angle,
    input  wire logic [dpe_pkg::ElapsedWidth-1:0]   i_elapsed_us,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic [dpe_pkg::PhaseWidth-1:0]          o_result_phase,
    output logic                                    o_started,
    output logic                                    o_tripped,
    input  wire logic                               i_cfg_we,
    input  wire logic [dpe_pkg::CfgIdxWidth-1:0]    i_cfg_idx,
    input  wire logic [dpe_pkg::CfgDataWidth-1:0]   i_cfg_data
);

    localparam int AW = (PHASES > 1) ? $clog2(PHASES) : 1;
    localparam int TW = dpe_pkg::TimerWidth;

    // configuration
    logic [dpe_pkg::MaskWidth-1:0]    r_phase_mask;
    logic [1:0]                       r_dir_mode;
    logic signed [dpe_pkg::AngleWidth-1:0] r_imp_angle;
    logic [dpe_pkg::AngleWidth-1:0]   r_angle_tol;
    logic [TW-1:0]                    r_delay;
    logic [dpe_pkg::MagWidth-1:0]     r_min_volt;
    logic [dpe_pkg::MagWidth-1:0]     r_min_curr;
    logic [dpe_pkg::CfgDataWidth-1:0] r_reach;

    // timer ram
    logic [TW-1:0]                    r_mem [PHASES];
    logic [PHASES-1:0]                r_mem_vld;
    logic [TW-1:0]                    r_rd_data;

    // compare stage
    logic                             r_s1_valid;
    logic [dpe_pkg::PhaseWidth-1:0]   r_s1_phase;
    logic [dpe_pkg::MagWidth-1:0]     r_s1_volt;
    logic [dpe_pkg::ElapsedWidth-1:0] r_s1_elapsed;
    dpe_pkg::t_front                  r_s1_front;

    // result register
    logic                             r_out_valid;
    logic [dpe_pkg::PhaseWidth-1:0]   r_out_phase;
    logic                             r_out_started;
    logic                             r_out_tripped;

    dpe_pkg::t_front                  w_front;
    logic                             w_accept;
    logic                             w_adv;
    logic                             w_in_zone;
    logic                             w_started;
    logic                             w_tripped;
    logic                             w_we;
    logic [TW-1:0]                    w_wdata;
    logic [TW:0]                      w_sum;
    logic [TW-1:0]                    w_timer;
    logic [AW-1:0]                    w_waddr;
    logic [AW-1:0]                    w_raddr;
    logic                             w_rd_in_range;
    logic                             w_fwd;

    dpe_front #(
        .PHASES(PHASES)
    ) u_front (
        .i_phase             (i_phase),
        .i_voltage_magnitude (i_voltage_magnitude),
        .i_current_magnitude (i_current_magnitude),
        .i_voltage_angle     (i_voltage_angle),
        .i_current_angle     (i_current_angle),
        .i_phase_mask        (r_phase_mask),
        .i_dir_mode          (r_dir_mode),
        .i_imp_angle         (r_imp_angle),
        .i_angle_tol         (r_angle_tol),
        .i_min_volt          (r_min_volt),
        .i_min_curr          (r_min_curr),
        .i_reach_table       (r_reach),
        .o_front             (w_front)
    );

    assign w_adv    = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready  = !r_s1_valid || !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_mask <= '0;
            r_dir_mode   <= '0;
            r_imp_angle  <= '0;
            r_angle_tol  <= '0;
            r_delay      <= '0;
            r_min_volt   <= '0;
            r_min_curr   <= '0;
            r_reach      <= '0;
        end else if (i_cfg_we) begin
            unique case (dpe_pkg::t_cfg_idx'(i_cfg_idx))
                dpe_pkg::CFG_PHASE_MASK: r_phase_mask <= i_cfg_data[dpe_pkg::MaskWidth-1:0];
                dpe_pkg::CFG_DIR_MODE:   r_dir_mode   <= i_cfg_data[1:0];
                dpe_pkg::CFG_IMP_ANGLE:  r_imp_angle  <= i_cfg_data[dpe_pkg::AngleWidth-1:0];
                dpe_pkg::CFG_ANGLE_TOL:  r_angle_tol  <= i_cfg_data[dpe_pkg::AngleWidth-1:0];
                dpe_pkg::CFG_DELAY:      r_delay      <= i_cfg_data[TW-1:0];
                dpe_pkg::CFG_MIN_VOLT:   r_min_volt   <= i_cfg_data[dpe_pkg::MagWidth-1:0];
                dpe_pkg::CFG_MIN_CURR:   r_min_curr   <= i_cfg_data[dpe_pkg::MagWidth-1:0];
                dpe_pkg::CFG_REACH:      r_reach      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zone decision and timer update
    always_comb begin
        w_in_zone = ({8'd0, r_s1_volt, 8'd0} <= r_s1_front.reach_prod);
        w_started = r_s1_front.enabled && r_s1_front.pre_ok && w_in_zone;
        w_sum     = {1'b0, r_rd_data} + {{(TW + 1 - dpe_pkg::ElapsedWidth){1'b0}}, r_s1_elapsed};
        w_timer   = w_sum[TW] ? '1 : w_sum[TW-1:0];
        w_we      = 1'b0;
        w_wdata   = '0;
        w_tripped = 1'b0;
        if (r_s1_front.enabled) begin
            if (!w_started) begin
                w_we = w_adv;
            end else if (r_delay == '0) begin
                w_tripped = 1'b1;
            end else begin
                w_we      = w_adv;
                w_wdata   = w_timer;
                w_tripped = (w_timer >= r_delay);
            end
        end
    end

    assign w_waddr       = r_s1_phase[AW-1:0];
    assign w_raddr       = i_phase[AW-1:0];
    assign w_rd_in_range = ({30'd0, i_phase} < PHASES);
    assign w_fwd         = w_we && (r_s1_phase == i_phase);

    // ram write
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld <= '0;
        end else if (w_we) begin
            r_mem_vld[w_waddr] <= 1'b1;
        end
    end

    // ram read with same-phase forwarding
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (w_fwd) begin
                r_rd_data <= w_wdata;
            end else if (w_rd_in_range && r_mem_vld[w_raddr]) begin
                r_rd_data <= r_mem[w_raddr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    // compare stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_phase   <= i_phase;
            r_s1_volt    <= i_voltage_magnitude;
            r_s1_elapsed <= i_elapsed_us;
            r_s1_front   <= w_front;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_phase   <= r_s1_phase;
            r_out_started <= w_started;
            r_out_tripped <= w_tripped;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_phase = r_out_phase;
    assign o_started      = r_out_started;
    assign o_tripped      = r_out_tripped;

`include "distance_protection_element_assert.svh"

    `DPE_ASSERT_SAME(a_trip_needs_start, o_valid && o_tripped, o_started)
    `DPE_ASSERT_SAME(a_write_only_on_advance, w_we, r_s1_valid && w_adv && r_s1_front.enabled)
    `DPE_ASSERT_SAME(a_stall_is_full, !o_ready, r_s1_valid && r_out_valid && !i_ready)
    `DPE_ASSERT_NEXT(a_forward_data, w_accept && w_fwd, r_rd_data == $past(w_wdata))

endmodule

`default_nettype wire
